// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, payload types and controller/datapath command and status
// structs for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int TAB_STOP = 4;
  localparam int TAB_W    = $clog2(TAB_STOP);

  // Character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Request function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_FG = 1'b0;
  localparam logic [0:0] REG_BG = 1'b1;

  // Cell content after reset
  localparam logic [15:0] RESET_CELL = 16'h0720;

  // Cursor and single-cell operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_SPACE,
    OP_NEWLINE,
    OP_RETURN,
    OP_BKSP,
    OP_HOME,
    OP_READ
  } op_e;

  // Sweep counter start points
  typedef enum logic [1:0] {
    SW_HOLD,
    SW_FROM_TOP,
    SW_FROM_SRC,
    SW_FROM_LAST
  } sweep_start_e;

  // Per-cycle sweep work
  typedef enum logic [1:0] {
    SWOP_NONE,
    SWOP_INIT,
    SWOP_BLANK,
    SWOP_COPY
  } sweep_op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [4:0]  line_start_row;
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
  } out_item_t;

  typedef struct packed {
    logic         load_item;
    op_e          op;
    sweep_start_e sweep_start;
    sweep_op_e    sweep_op;
    logic         load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_newline;
    logic       is_return;
    logic       is_backspace;
    logic       is_tab;
    logic       col_last;
    logic       row_last;
    logic       tab_stop;
    logic       sweep_last;
    logic       out_free;
  } dp_status_t;

  // Build a cell from colors and character
  function automatic logic [15:0] make_cell(logic [3:0] fg, logic [3:0] bg,
                                            logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage

// ===== design/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes each request, steps tab fills, and runs the reset fill,
// clear, and scroll sweeps over the cell memory.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_TAB      = 4'd3;
  localparam logic [3:0] S_CLEAR    = 4'd4;
  localparam logic [3:0] S_SCROLL   = 4'd5;
  localparam logic [3:0] S_SCR_TAIL = 4'd6;
  localparam logic [3:0] S_BLANK    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_op = SWOP_INIT;
        if (status_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        priority if (status_i.func == FUNC_READ) begin
          cmd_o.op = OP_READ;
        end else if (status_i.func == FUNC_CLEAR) begin
          cmd_o.op          = OP_HOME;
          cmd_o.sweep_start = SW_FROM_TOP;
          state_d           = S_CLEAR;
        end else if (status_i.func == FUNC_PUT) begin
          priority if (status_i.is_newline) begin
            cmd_o.op = OP_NEWLINE;
            if (status_i.row_last) begin
              cmd_o.sweep_start = SW_FROM_SRC;
              state_d           = S_SCROLL;
            end
          end else if (status_i.is_return) begin
            cmd_o.op = OP_RETURN;
          end else if (status_i.is_backspace) begin
            cmd_o.op = OP_BKSP;
          end else if (status_i.is_tab) begin
            state_d = S_TAB;
          end else begin
            cmd_o.op = OP_PUT;
            if (status_i.col_last && status_i.row_last) begin
              cmd_o.sweep_start = SW_FROM_SRC;
              state_d           = S_SCROLL;
            end
          end
        end else begin
          cmd_o.op = OP_NONE;
        end
      end
      S_TAB: begin
        // One space per cycle; stop at a tab stop or on wrap
        cmd_o.op = OP_SPACE;
        priority if (status_i.col_last) begin
          if (status_i.row_last) begin
            cmd_o.sweep_start = SW_FROM_SRC;
            state_d           = S_SCROLL;
          end else begin
            state_d = S_DONE;
          end
        end else if (status_i.tab_stop) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TAB;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_op = SWOP_BLANK;
        if (status_i.sweep_last) state_d = S_DONE;
      end
      S_SCROLL: begin
        cmd_o.sweep_op = SWOP_COPY;
        if (status_i.sweep_last) state_d = S_SCR_TAIL;
      end
      S_SCR_TAIL: begin
        // Last copy write drains here
        cmd_o.sweep_start = SW_FROM_LAST;
        state_d           = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.sweep_op = SWOP_BLANK;
        if (status_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cell memory, cursor and line-start registers, color registers,
// sweep counter for fill/copy passes, and the result register.
// ----------------------------------------------------------------------------
module tcw_dp
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  logic [15:0]       mem_q [CELLS];
  logic [15:0]       rd_q;
  in_item_t          item_q;
  logic [3:0]        fg_q, bg_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d, ls_q, ls_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              cp_vld_q;
  logic [ADDR_W-1:0] cp_dst_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              col_last, row_last, col_zero;
  logic              bs_blocked;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  tgt_row;
  logic [ADDR_W-1:0] tgt_addr, cur_addr;
  logic [15:0]       blank_cell;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       wr_data;
  logic              addr_ok;

  assign col_last   = (col_q == COL_W'(COLUMNS - 1));
  assign row_last   = (row_q == ROW_W'(ROWS - 1));
  assign col_zero   = (col_q == '0);
  assign bs_blocked = col_zero && ((row_q == ls_q) || (row_q == '0));
  assign blank_cell = make_cell(fg_q, bg_q, CH_SPACE);
  assign cur_addr   = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign addr_ok    = ({21'd0, item_q.cell_address} < 32'(CELLS));

  // Backspace target cell: previous column, or end of the row above
  always_comb begin
    if (col_zero) begin
      tgt_row = row_q - ROW_W'(1);
      tgt_col = COL_W'(COLUMNS - 1);
    end else begin
      tgt_row = row_q;
      tgt_col = col_q - COL_W'(1);
    end
  end
  assign tgt_addr = ADDR_W'(tgt_row) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col);

  // Status to the controller
  always_comb begin
    status_o.func         = item_q.func;
    status_o.is_newline   = (item_q.char_code == CH_NEWLINE);
    status_o.is_return    = (item_q.char_code == CH_RETURN);
    status_o.is_backspace = (item_q.char_code == CH_BACKSPACE);
    status_o.is_tab       = (item_q.char_code == CH_TAB);
    status_o.col_last     = col_last;
    status_o.row_last     = row_last;
    status_o.tab_stop     = (col_q[TAB_W-1:0] == {TAB_W{1'b1}});
    status_o.sweep_last   = (sweep_q == ADDR_W'(CELLS - 1));
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Cursor and line-start update
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ls_d  = ls_q;
    unique case (cmd_i.op)
      OP_PUT, OP_SPACE: begin
        if (col_last) begin
          col_d = '0;
          if (row_last) begin
            // Wrap off the bottom: screen scrolls, line start moves up
            if (ls_q != '0) ls_d = ls_q - ROW_W'(1);
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      OP_NEWLINE: begin
        col_d = '0;
        if (row_last) begin
          ls_d = ROW_W'(ROWS - 1);
        end else begin
          row_d = row_q + ROW_W'(1);
          ls_d  = row_q + ROW_W'(1);
        end
      end
      OP_RETURN: begin
        col_d = '0;
        row_d = ls_q;
      end
      OP_BKSP: begin
        if (!bs_blocked) begin
          col_d = tgt_col;
          row_d = tgt_row;
        end
      end
      OP_HOME: begin
        col_d = '0;
        row_d = '0;
        ls_d  = '0;
      end
      OP_NONE, OP_READ: begin
        col_d = col_q;
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  // Sweep counter
  always_comb begin
    sweep_d = sweep_q;
    unique case (cmd_i.sweep_start)
      SW_FROM_TOP:  sweep_d = '0;
      SW_FROM_SRC:  sweep_d = ADDR_W'(COLUMNS);
      SW_FROM_LAST: sweep_d = ADDR_W'((ROWS - 1) * COLUMNS);
      SW_HOLD: begin
        if (cmd_i.sweep_op != SWOP_NONE) sweep_d = sweep_q + ADDR_W'(1);
      end
      default: sweep_d = sweep_q;
    endcase
  end

  // Memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_q;
    wr_data = blank_cell;
    priority if (cp_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = cp_dst_q;
      wr_data = rd_q;
    end else if (cmd_i.sweep_op == SWOP_INIT) begin
      wr_en   = 1'b1;
      wr_data = RESET_CELL;
    end else if (cmd_i.sweep_op == SWOP_BLANK) begin
      wr_en   = 1'b1;
    end else if (cmd_i.op == OP_PUT) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = make_cell(fg_q, bg_q, item_q.char_code);
    end else if (cmd_i.op == OP_SPACE) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
    end else if (cmd_i.op == OP_BKSP) begin
      wr_en   = !bs_blocked;
      wr_addr = tgt_addr;
    end else begin
      wr_en   = 1'b0;
    end
  end

  assign rd_en   = (cmd_i.op == OP_READ) || (cmd_i.sweep_op == SWOP_COPY);
  assign rd_addr = (cmd_i.op == OP_READ) ? ADDR_W'(item_q.cell_address) : sweep_q;

  // Cell memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Copy destination trails the read address by one row
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_op == SWOP_COPY) cp_dst_q <= sweep_q - ADDR_W'(COLUMNS);
  end

  // Latch the request and the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.load_out) begin
      out_q.cursor_column  <= 7'(col_q);
      out_q.cursor_row     <= 5'(row_q);
      out_q.line_start_row <= 5'(ls_q);
      out_q.cursor_offset  <= 11'(cur_addr);
      out_q.cell_data      <= (item_q.func == FUNC_READ && addr_ok) ? rd_q : 16'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      ls_q        <= '0;
      sweep_q     <= '0;
      cp_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fg_q        <= 4'd7;
      bg_q        <= 4'd0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      ls_q     <= ls_d;
      sweep_q  <= sweep_d;
      cp_vld_q <= (cmd_i.sweep_op == SWOP_COPY);
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && cfg_idx_i == REG_FG) fg_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_BG) bg_q <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console writer: character cell store with cursor, line tracking,
// control characters, scrolling and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with in_data_i (func, char_code,
//   cell_address); each request gives exactly one result on
//   out_valid_o/out_ready_i with the cursor state and, for reads, the cell.
//   Colors are to be written through cfg_we_i/cfg_idx_i/cfg_data_i while
//   idle; the block itself does not enforce this. The sequencer accepts
//   no new request until the result of the previous one is loaded. A put,
//   control character, read or unused func is decoded and gives its
//   result; a tab writes 1 to 4 spaces; a scroll (newline or wrap on the
//   last row) copies every row up by one over the cell memory and blanks
//   the last row; a clear blanks all cells.
//   After reset the block fills all CELLS (2000) cells with 0x0720, one per
//   cycle, and holds in_ready_o low during that pass; color writes are
//   taken at any time. The result register is separate from the sequencer,
//   so a stalled receiver holds only the final step of the next request.
// ----------------------------------------------------------------------------
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Memory, cursor and result registers
  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
